@@ hdl/pasd_pkg.sv @@
`default_nettype none

package pasd_pkg;

    // Coordinate format and derived widths of the angle datapath.
    localparam int COORD_WIDTH = 16;
    localparam int MAG_W       = COORD_WIDTH;
    localparam int TWO_W       = COORD_WIDTH + 1;
    localparam int CMP_W       = COORD_WIDTH + 8;
    localparam int DEN_W       = COORD_WIDTH + 6;
    localparam int QUO_W       = 13;
    localparam int NUM_W       = DEN_W + QUO_W;
    localparam int SEGS        = 8;
    localparam int SEG_W       = 3;

    // Result widths.
    localparam int ANGLE_W     = 17;
    localparam int MAG_ANG_W   = 15;
    localparam int COUNT_W     = 15;
    localparam int DUTY_W      = 10;

    // Count scaling: count = (angle + 180 deg) * 561111 / 2560000.
    // The divide by 2560000 is a shift by 12 and a divide by 625, and the
    // divide by 625 is a reciprocal multiply with one correction step.
    localparam int PROD_W      = ANGLE_W + 20;
    localparam int T_W         = 24;
    localparam int RECIP_W     = 15;
    localparam int EST_W       = T_W + RECIP_W;
    localparam int SCALE_SHIFT = 12;
    localparam int RECIP_SHIFT = 24;
    localparam int DUTY_SHIFT  = 8;

    localparam logic [19:0]          SCALE_MUL   = 20'd561111;
    localparam logic [RECIP_W-1:0]   RECIP       = 15'd26843;
    localparam logic [9:0]           SCALE_DIV   = 10'd625;
    localparam logic [2:0]           DUTY_MUL    = 3'd5;
    localparam logic [COUNT_W-1:0]   COUNT_LIMIT = 15'd20000;
    localparam logic [MAG_ANG_W-1:0] ANGLE_90    = 15'd23040;
    localparam logic [ANGLE_W:0]     ANGLE_180   = 18'd46080;

    // Arctangent breakpoints, ratios in halves, angles in 1/256 degree.
    // Entry j describes the segment from breakpoint j to breakpoint j+1.
    localparam logic [7:0] LIMIT_HALF [0:SEGS-1] =
        '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd40, 8'd80, 8'd200};
    localparam logic [7:0] BASE_HALF [0:SEGS-1] =
        '{8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd40, 8'd80};
    localparam logic [7:0] STEP_HALF [0:SEGS-1] =
        '{8'd1, 8'd1, 8'd2, 8'd4, 8'd8, 8'd24, 8'd40, 8'd120};
    localparam logic [MAG_ANG_W-1:0] BASE_ANGLE [0:SEGS-1] =
        '{15'd0, 15'd6802, 15'd11520, 15'd16238,
          15'd19446, 15'd21215, 15'd22308, 15'd22674};
    localparam logic [QUO_W-1:0] STEP_ANGLE [0:SEGS-1] =
        '{13'd6802, 13'd4718, 13'd4718, 13'd3208,
          13'd1769, 13'd1093, 13'd366, 13'd220};

    // Input beat: one target point.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_pos;
        logic signed [COORD_WIDTH-1:0] y_pos;
    } point_t;

    // Output beat: angle, count, duty code and its valid flag.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] pan_angle;
        logic [COUNT_W-1:0]        pan_count;
        logic [DUTY_W-1:0]         duty_code;
        logic                      code_valid;
    } result_t;

    // Quadrant and segment information that rides along with the datapath.
    typedef struct packed {
        logic             neg_ratio;
        logic             add_half;
        logic             sub_half;
        logic             sat;
        logic [SEG_W-1:0] seg;
    } side_t;

    // One beat inside the divider pipeline.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        side_t            side;
    } div_beat_t;

endpackage

`default_nettype wire

@@ hdl/pan_angle_servo_duty.sv @@
`default_nettype none

// Channel   Beat type          Handshake          Content
// pt        pasd_pkg::point_t  pt_valid/stall     target x_pos, y_pos (signed)
// res       pasd_pkg::result_t res_valid/stall    pan_angle, pan_count, duty_code,
//                                                 code_valid
//
// A new point is taken in every cycle unless pt is stalled; each beat passes
// through four front stages, thirteen divider stages (one quotient bit each)
// and five back stages for angle, scaling and duty code.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall on res holds only the stages that are full; empty stages keep
// filling, so pt stalls only when the whole pipeline is occupied.
module pan_angle_servo_duty (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pt_valid,
    output logic                   pt_stall,
    input  wire pasd_pkg::point_t  pt_data,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output pasd_pkg::result_t      res_data
);

    localparam int W = pasd_pkg::COORD_WIDTH;

    // Stage valid bits and ready chain.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic a_vld_reg, p_vld_reg, e_vld_reg, c_vld_reg, o_vld_reg;
    logic rdy_1, rdy_2, rdy_3, rdy_4;
    logic rdy_a, rdy_p, rdy_e, rdy_c, rdy_o;
    logic div_src_stall, div_dst_valid;

    // Front stage payloads.
    logic [pasd_pkg::MAG_W-1:0] ax1_reg, ay1_reg, ax1_next, ay1_next;
    pasd_pkg::side_t            side1_reg, side1_next;
    logic [pasd_pkg::MAG_W-1:0] ax2_reg;
    logic [pasd_pkg::TWO_W-1:0] twoy2_reg, twoy2_next;
    pasd_pkg::side_t            side2_reg, side2_next;
    logic [pasd_pkg::DEN_W-1:0] rem3_reg, rem3_next, den3_reg, den3_next;
    pasd_pkg::side_t            side3_reg;
    pasd_pkg::div_beat_t        beat4_reg, beat4_next, div_out;

    // Back stage payloads.
    logic signed [pasd_pkg::ANGLE_W-1:0] angle_a_reg, angle_a_next;
    logic signed [pasd_pkg::ANGLE_W-1:0] angle_p_reg, angle_e_reg, angle_c_reg;
    logic [pasd_pkg::PROD_W-1:0]         prod_p_reg, prod_p_next;
    logic [pasd_pkg::T_W-1:0]            t_e_reg, t_e_next;
    logic [pasd_pkg::EST_W-1:0]          est_e_reg, est_e_next;
    logic [pasd_pkg::COUNT_W-1:0]        count_c_reg, count_c_next;
    logic                                valid_c_reg, valid_c_next;
    pasd_pkg::result_t                   out_reg, out_next;

    // Ready chain from the output back to the input.
    always_comb
    begin
        rdy_o = !o_vld_reg || !res_stall;
        rdy_c = !c_vld_reg || rdy_o;
        rdy_e = !e_vld_reg || rdy_c;
        rdy_p = !p_vld_reg || rdy_e;
        rdy_a = !a_vld_reg || rdy_p;
        rdy_4 = !s4_vld_reg || !div_src_stall;
        rdy_3 = !s3_vld_reg || rdy_4;
        rdy_2 = !s2_vld_reg || rdy_3;
        rdy_1 = !s1_vld_reg || rdy_2;
    end

    assign pt_stall = !rdy_1;

    // Stage 1: magnitudes and quadrant flags.
    always_comb
    begin
        logic [W-1:0] xu;
        logic [W-1:0] yu;
        logic         xneg;
        logic         yneg;
        logic         ax_zero;
        logic         ay_zero;
        xu       = pt_data.x_pos;
        yu       = pt_data.y_pos;
        xneg     = xu[W-1];
        yneg     = yu[W-1];
        ax1_next = xneg ? (~xu + pasd_pkg::MAG_W'(1)) : xu;
        ay1_next = yneg ? (~yu + pasd_pkg::MAG_W'(1)) : yu;
        ax_zero  = (ax1_next == '0);
        ay_zero  = (ay1_next == '0);
        side1_next.neg_ratio = (xneg && !yneg && !ay_zero) || (!xneg && !ax_zero && yneg)
                             || (ax_zero && yneg);
        side1_next.add_half  = xneg && !yneg;
        side1_next.sub_half  = xneg && yneg;
        side1_next.sat       = 1'b0;
        side1_next.seg       = '0;
    end

    // Stage 2: segment search, all breakpoints compared side by side.
    always_comb
    begin
        logic [pasd_pkg::CMP_W-1:0] lim;
        twoy2_next     = {ay1_reg, 1'b0};
        side2_next     = side1_reg;
        side2_next.sat = 1'b1;
        side2_next.seg = '0;
        for (int j = pasd_pkg::SEGS - 1; j >= 0; j--)
        begin
            lim = pasd_pkg::CMP_W'(ax1_reg) * pasd_pkg::CMP_W'(pasd_pkg::LIMIT_HALF[j]);
            if (lim > pasd_pkg::CMP_W'(twoy2_next))
            begin
                side2_next.sat = 1'b0;
                side2_next.seg = pasd_pkg::SEG_W'(j);
            end
        end
    end

    // Stage 3: offset into the segment and the segment width.
    always_comb
    begin
        logic [pasd_pkg::CMP_W-1:0] base;
        base      = pasd_pkg::CMP_W'(ax2_reg)
                  * pasd_pkg::CMP_W'(pasd_pkg::BASE_HALF[side2_reg.seg]);
        rem3_next = pasd_pkg::DEN_W'(pasd_pkg::CMP_W'(twoy2_reg) - base);
        den3_next = pasd_pkg::DEN_W'(pasd_pkg::DEN_W'(ax2_reg)
                  * pasd_pkg::DEN_W'(pasd_pkg::STEP_HALF[side2_reg.seg]));
    end

    // Stage 4: scale the offset by the segment's angle step.
    always_comb
    begin
        beat4_next.rem  = pasd_pkg::NUM_W'(rem3_reg)
                        * pasd_pkg::NUM_W'(pasd_pkg::STEP_ANGLE[side3_reg.seg]);
        beat4_next.den  = den3_reg;
        beat4_next.quo  = '0;
        beat4_next.side = side3_reg;
    end

    pasd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (s4_vld_reg),
        .src_stall (div_src_stall),
        .src_beat  (beat4_reg),
        .dst_valid (div_dst_valid),
        .dst_stall (!rdy_a),
        .dst_beat  (div_out)
    );

    // Stage a: interpolated magnitude, sign and half-turn correction.
    always_comb
    begin
        logic [pasd_pkg::MAG_ANG_W-1:0] mag;
        logic signed [pasd_pkg::ANGLE_W:0] s;
        mag = div_out.side.sat ? pasd_pkg::ANGLE_90
            : pasd_pkg::BASE_ANGLE[div_out.side.seg] + pasd_pkg::MAG_ANG_W'(div_out.quo);
        s = signed'({3'b000, mag});
        if (div_out.side.neg_ratio)
            s = -s;
        if (div_out.side.add_half)
            s = s + signed'(pasd_pkg::ANGLE_180);
        else if (div_out.side.sub_half)
            s = s - signed'(pasd_pkg::ANGLE_180);
        angle_a_next = s[pasd_pkg::ANGLE_W-1:0];
    end

    // Stage p: shift to 0..360 degrees and multiply by the count scale.
    always_comb
    begin
        logic [pasd_pkg::ANGLE_W:0] sum;
        sum = unsigned'((pasd_pkg::ANGLE_W + 1)'(angle_a_reg)) + pasd_pkg::ANGLE_180;
        prod_p_next = pasd_pkg::PROD_W'(sum[pasd_pkg::ANGLE_W-1:0])
                    * pasd_pkg::PROD_W'(pasd_pkg::SCALE_MUL);
    end

    // Stage e: drop the power-of-two part, estimate the divide by 625.
    always_comb
    begin
        t_e_next   = prod_p_reg[pasd_pkg::SCALE_SHIFT +: pasd_pkg::T_W];
        est_e_next = pasd_pkg::EST_W'(t_e_next) * pasd_pkg::EST_W'(pasd_pkg::RECIP);
    end

    // Stage c: the estimate is exact or one low; fix it from the remainder.
    always_comb
    begin
        logic [pasd_pkg::COUNT_W-1:0] qest;
        logic [pasd_pkg::T_W-1:0]     back;
        logic [pasd_pkg::T_W-1:0]     r;
        qest = est_e_reg[pasd_pkg::RECIP_SHIFT +: pasd_pkg::COUNT_W];
        back = pasd_pkg::T_W'(pasd_pkg::T_W'(qest) * pasd_pkg::T_W'(pasd_pkg::SCALE_DIV));
        r    = t_e_reg - back;
        count_c_next = qest + pasd_pkg::COUNT_W'(r >= pasd_pkg::T_W'(pasd_pkg::SCALE_DIV));
        valid_c_next = (count_c_next <= pasd_pkg::COUNT_LIMIT);
    end

    // Stage o: duty code is count * 5 / 256 when the count is in range.
    always_comb
    begin
        logic [pasd_pkg::COUNT_W+2:0] dprod;
        dprod = (pasd_pkg::COUNT_W + 3)'(count_c_reg)
              * (pasd_pkg::COUNT_W + 3)'(pasd_pkg::DUTY_MUL);
        out_next.pan_angle  = angle_c_reg;
        out_next.pan_count  = count_c_reg;
        out_next.duty_code  = valid_c_reg ? dprod[pasd_pkg::DUTY_SHIFT +: pasd_pkg::DUTY_W]
                                          : '0;
        out_next.code_valid = valid_c_reg;
    end

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
            p_vld_reg  <= 1'b0;
            e_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_1) s1_vld_reg <= pt_valid;
            if (rdy_2) s2_vld_reg <= s1_vld_reg;
            if (rdy_3) s3_vld_reg <= s2_vld_reg;
            if (rdy_4) s4_vld_reg <= s3_vld_reg;
            if (rdy_a) a_vld_reg  <= div_dst_valid;
            if (rdy_p) p_vld_reg  <= a_vld_reg;
            if (rdy_e) e_vld_reg  <= p_vld_reg;
            if (rdy_c) c_vld_reg  <= e_vld_reg;
            if (rdy_o) o_vld_reg  <= c_vld_reg;
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge clk)
    begin
        if (rdy_1)
        begin
            ax1_reg   <= ax1_next;
            ay1_reg   <= ay1_next;
            side1_reg <= side1_next;
        end
        if (rdy_2)
        begin
            ax2_reg   <= ax1_reg;
            twoy2_reg <= twoy2_next;
            side2_reg <= side2_next;
        end
        if (rdy_3)
        begin
            rem3_reg  <= rem3_next;
            den3_reg  <= den3_next;
            side3_reg <= side2_reg;
        end
        if (rdy_4)
            beat4_reg <= beat4_next;
        if (rdy_a)
            angle_a_reg <= angle_a_next;
        if (rdy_p)
        begin
            angle_p_reg <= angle_a_reg;
            prod_p_reg  <= prod_p_next;
        end
        if (rdy_e)
        begin
            angle_e_reg <= angle_p_reg;
            t_e_reg     <= t_e_next;
            est_e_reg   <= est_e_next;
        end
        if (rdy_c)
        begin
            angle_c_reg <= angle_e_reg;
            count_c_reg <= count_c_next;
            valid_c_reg <= valid_c_next;
        end
        if (rdy_o)
            out_reg <= out_next;
    end

    assign res_valid = o_vld_reg;
    assign res_data  = out_reg;

endmodule

`default_nettype wire

@@ hdl/pasd_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage, MSB first.
module pasd_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                src_valid,
    output logic                     src_stall,
    input  wire pasd_pkg::div_beat_t src_beat,
    output logic                     dst_valid,
    input  wire logic                dst_stall,
    output pasd_pkg::div_beat_t      dst_beat
);

    localparam int STAGES = pasd_pkg::QUO_W;

    logic [STAGES-1:0]   vld_reg;
    logic [STAGES-1:0]   rdy;
    pasd_pkg::div_beat_t beat_reg  [STAGES];
    pasd_pkg::div_beat_t beat_prev [STAGES];
    pasd_pkg::div_beat_t beat_next [STAGES];

    // A stage loads when it is empty or its successor is loading.
    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || !dst_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        localparam int K = STAGES - 1 - g;

        // Stage input comes from the port or from the stage before.
        if (g == 0)
        begin : g_first
            assign beat_prev[g] = src_beat;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (rdy[g])
                    vld_reg[g] <= src_valid;
            end
        end
        else
        begin : g_rest
            assign beat_prev[g] = beat_reg[g-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (rdy[g])
                    vld_reg[g] <= vld_reg[g-1];
            end
        end

        // Trial subtraction of the shifted divisor sets quotient bit K.
        always_comb
        begin
            beat_next[g] = beat_prev[g];
            if (beat_prev[g].rem >= (pasd_pkg::NUM_W'(beat_prev[g].den) << K))
            begin
                beat_next[g].rem    = beat_prev[g].rem
                                    - (pasd_pkg::NUM_W'(beat_prev[g].den) << K);
                beat_next[g].quo[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[g])
                beat_reg[g] <= beat_next[g];
        end
    end

    assign src_stall = !rdy[0];
    assign dst_valid = vld_reg[STAGES-1];
    assign dst_beat  = beat_reg[STAGES-1];

endmodule

`default_nettype wire

@@ hdl/pasd_checker.sv @@
`default_nettype none

// Port-level checks on the pan angle block.
module pasd_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pt_valid,
    input  wire logic              pt_stall,
    input  wire pasd_pkg::point_t  pt_data,
    input  wire logic              res_valid,
    input  wire logic              res_stall,
    input  wire pasd_pkg::result_t res_data
);

    // A stalled result beat stays and keeps its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // The code is flagged valid exactly when the count is in range.
    a_valid_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.code_valid == (res_data.pan_count <= 15'd20000)))
        else $error("code_valid disagrees with pan_count");

    // The duty code follows from the count, and is zero when not valid.
    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.duty_code == (res_data.code_valid
            ? 10'((18'(res_data.pan_count) * 18'd5) >> 8) : 10'd0)))
        else $error("duty_code inconsistent with pan_count");

    // The angle stays within a half turn either way.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.pan_angle >= -17'sd46080)
                   && (res_data.pan_angle <= 17'sd46080))
        else $error("pan_angle out of range");

    // A stalled point beat stays and keeps its value.
    a_pt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && pt_stall |=> pt_valid && $stable(pt_data))
        else $error("point beat changed while stalled");

endmodule

bind pan_angle_servo_duty pasd_checker u_pasd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt_data   (pt_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

`default_nettype wire
